/* rtl/iis_pkg.sv */
`timescale 1ns / 1ps

package iis_pkg;

  localparam int MAX_WIDTH_DEF = 4096;

  localparam int PIX_W   = 8;
  localparam int SUM_W   = 32;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int SIZE_W  = 14;
  localparam int ROW_W   = 12;

  localparam int HEIGHT_LIMIT = 4096;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(4096);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(4096);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [CFG_W-1:0]  height;
  } frame_size_t;

endpackage

/* rtl/iis_pixel_if.sv */
`timescale 1ns / 1ps

interface iis_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [iis_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

/* rtl/iis_result_if.sv */
`timescale 1ns / 1ps

interface iis_result_if;
  logic                       valid;
  logic                       ready;
  logic [iis_pkg::SUM_W-1:0]  integral_value;
  logic                       row_end;
  logic                       frame_end;

  modport source (output valid, output integral_value, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input integral_value, input row_end, input frame_end,
                  output ready);
endinterface

/* rtl/iis_cfg_if.sv */
`timescale 1ns / 1ps

interface iis_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [iis_pkg::CFG_IDX_W-1:0]  index;
  logic [iis_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/iis_cfg_regs.sv */
`timescale 1ns / 1ps

module iis_cfg_regs #(
  parameter int MAX_WIDTH = iis_pkg::MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  iis_cfg_if.sink              cfg_ch,
  output iis_pkg::frame_size_t size
);

  logic [iis_pkg::CFG_W-1:0] width_r;
  logic [iis_pkg::CFG_W-1:0] height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= iis_pkg::WIDTH_RST;
      height_r <= iis_pkg::HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        iis_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_ch.data;
        iis_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // clamp to the supported frame size; zero acts as one
  always_comb begin
    if (width_r == '0) begin
      size.width = iis_pkg::SIZE_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      size.width = iis_pkg::SIZE_W'(MAX_WIDTH);
    end else begin
      size.width = iis_pkg::SIZE_W'(width_r);
    end
    if (height_r == '0) begin
      size.height = iis_pkg::CFG_W'(1);
    end else if (32'(height_r) > iis_pkg::HEIGHT_LIMIT) begin
      size.height = iis_pkg::CFG_W'(iis_pkg::HEIGHT_LIMIT);
    end else begin
      size.height = height_r;
    end
  end

endmodule

/* rtl/iis_line_store.sv */
`timescale 1ns / 1ps

module iis_line_store #(
  parameter int MAX_WIDTH = iis_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [iis_pkg::SUM_W-1:0]  rdata,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [iis_pkg::SUM_W-1:0]  wdata
);

  logic [iis_pkg::SUM_W-1:0] mem [MAX_WIDTH];
  logic [iis_pkg::SUM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/integral_image_stream.sv */
`timescale 1ns / 1ps
// Each pixel is registered in stage 1, and its result in the output register, before out_ch offers it.
// Throughput: one pixel per cycle while out_ch is ready, with one read port and one write port on the line store.
// Reset (rst_n low, synchronous): counters, row sum and pipeline valids clear; width and
// height return to 4096. The line store is not cleared: the first row never uses what it reads.

module integral_image_stream #(
  parameter int MAX_WIDTH = iis_pkg::MAX_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  iis_pixel_if.sink     in_ch,
  iis_result_if.source  out_ch,
  iis_cfg_if.sink       cfg_ch
);

  localparam int CW = $clog2(MAX_WIDTH);

  iis_pkg::frame_size_t size;

  logic [CW-1:0]                col_r;
  logic [iis_pkg::ROW_W-1:0]    row_r;
  logic [iis_pkg::SUM_W-1:0]    rs_r;

  logic                         s1_valid_r;
  logic [CW-1:0]                s1_col_r;
  logic [iis_pkg::SUM_W-1:0]    s1_rs_r;
  logic                         s1_top_r;
  logic                         s1_fwd_r;
  logic                         s1_row_end_r;
  logic                         s1_frame_end_r;

  logic [iis_pkg::SUM_W-1:0]    wval_r;

  logic                         out_valid_r;
  logic [iis_pkg::SUM_W-1:0]    out_val_r;
  logic                         out_row_end_r;
  logic                         out_frame_end_r;

  logic                         accept;
  logic                         s1_adv;
  logic [CW:0]                  col_inc;
  logic [iis_pkg::CFG_W-1:0]    row_inc;
  logic                         row_end;
  logic                         frame_end;
  logic [iis_pkg::SUM_W-1:0]    rs_nxt;
  logic [iis_pkg::SUM_W-1:0]    rdata;
  logic [iis_pkg::SUM_W-1:0]    above;
  logic [iis_pkg::SUM_W-1:0]    val;

  iis_cfg_regs #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .size   (size)
  );

  iis_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .re    (accept),
    .raddr (col_r),
    .rdata (rdata),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (val)
  );

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign row_inc   = {1'b0, row_r} + 1'b1;
  assign row_end   = 32'(col_inc) >= 32'(size.width);
  assign frame_end = row_end && (row_inc >= size.height);
  assign rs_nxt    = rs_r + iis_pkg::SUM_W'(in_ch.pixel);

  // take the entry just written when the read hit the same column in the same cycle
  always_comb begin
    if (s1_top_r) begin
      above = '0;
    end else if (s1_fwd_r) begin
      above = wval_r;
    end else begin
      above = rdata;
    end
  end
  assign val = s1_rs_r + above;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      rs_r  <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_r <= '0;
        rs_r  <= '0;
        row_r <= frame_end ? '0 : row_inc[iis_pkg::ROW_W-1:0];
      end else begin
        col_r <= col_inc[CW-1:0];
        rs_r  <= rs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r       <= col_r;
      s1_rs_r        <= rs_nxt;
      s1_top_r       <= row_r == '0;
      s1_fwd_r       <= s1_adv && (s1_col_r == col_r);
      s1_row_end_r   <= row_end;
      s1_frame_end_r <= frame_end;
    end
    if (s1_adv) begin
      wval_r <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_val_r       <= val;
      out_row_end_r   <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.integral_value = out_val_r;
  assign out_ch.row_end        = out_row_end_r;
  assign out_ch.frame_end      = out_frame_end_r;

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end_r |-> out_row_end_r)
    else $error("frame end without row end");

  a_fwd_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_fwd_r |-> s1_col_r == '0)
    else $error("line store bypass on a column other than the first");

  a_row_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    col_r == '0 |-> rs_r == '0)
    else $error("row sum not cleared at the start of a row");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && row_end |=> col_r == '0)
    else $error("column count not wrapped after the last pixel of a row");

endmodule

/* verif/tb_integral_image_stream.sv */
`timescale 1ns / 1ps

module tb_integral_image_stream;

  localparam int MAX_W        = iis_pkg::MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_TAIL    = 250;
  localparam int QUIET_LIMIT  = 1000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [iis_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = iis_pkg::CFG_IDX_W'(2);
  localparam logic [iis_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = iis_pkg::CFG_IDX_W'(3);
  localparam logic [iis_pkg::CFG_W-1:0]     SIZE_CFG_MAX = '1;

  typedef struct packed {
    logic [iis_pkg::SUM_W-1:0] integral_value;
    logic                      row_end;
    logic                      frame_end;
  } sat_result_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t                    kind;
    logic [iis_pkg::CFG_IDX_W-1:0] index;
    logic [iis_pkg::CFG_W-1:0]     data;
    logic [iis_pkg::PIX_W-1:0]     pixel;
    logic                          pinned;
    sat_result_t                   want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  iis_pixel_if  pix_bus ();
  iis_result_if res_bus ();
  iis_cfg_if    cfg_bus ();

  integral_image_stream dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_bus),
    .out_ch (res_bus),
    .cfg_ch (cfg_bus)
  );

  always #5 clk = ~clk;

  logic [iis_pkg::CFG_W-1:0] width_reg  = iis_pkg::WIDTH_RST;
  logic [iis_pkg::CFG_W-1:0] height_reg = iis_pkg::HEIGHT_RST;
  logic [iis_pkg::SUM_W-1:0] line_sums [MAX_W];
  logic [iis_pkg::SUM_W-1:0] row_acc = '0;
  logic [iis_pkg::ROW_W-1:0] col_pos = '0;
  logic [iis_pkg::ROW_W-1:0] row_pos = '0;
  int unsigned      store_span = 0;
  sat_result_t      pending_sums [$];
  logic             pin_now = 1'b0;
  sat_result_t      pin_want = '0;
  logic             src_gaps = 1'b0;
  logic             sink_stalls = 1'b0;
  int unsigned      quiet_cycles = 0;
  int unsigned      errors = 0;
  script_row_t      script [$];

  function automatic logic [iis_pkg::SIZE_W-1:0] span_of(
      input logic [iis_pkg::CFG_W-1:0] v, input int unsigned cap);
    if (v == '0) return iis_pkg::SIZE_W'(1);
    if (v > cap) return iis_pkg::SIZE_W'(cap);
    return iis_pkg::SIZE_W'(v);
  endfunction

  function automatic sat_result_t next_integral(input logic [iis_pkg::PIX_W-1:0] p);
    logic [iis_pkg::SIZE_W-1:0] w;
    logic [iis_pkg::SIZE_W-1:0] h;
    logic [iis_pkg::SUM_W-1:0]  line_sum;
    logic [iis_pkg::SUM_W-1:0]  above;
    sat_result_t                r;
    w = span_of(width_reg, MAX_W);
    h = span_of(height_reg, iis_pkg::HEIGHT_LIMIT);
    line_sum = row_acc + iis_pkg::SUM_W'(p);
    above = (row_pos != '0) ? line_sums[col_pos] : '0;
    r.integral_value = line_sum + above;
    line_sums[col_pos] = r.integral_value;
    if (int'(col_pos) + 1 > store_span) store_span = int'(col_pos) + 1;
    r.row_end = (int'(col_pos) + 1) >= int'(w);
    r.frame_end = r.row_end && ((int'(row_pos) + 1) >= int'(h));
    if (r.row_end) begin
      col_pos = '0;
      row_acc = '0;
      row_pos = r.frame_end ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
      row_acc = line_sum;
    end
    return r;
  endfunction

  function automatic script_row_t pixel_row(input logic [iis_pkg::PIX_W-1:0] p);
    script_row_t r;
    r = '0;
    r.kind = STEP_PIXEL;
    r.pixel = p;
    return r;
  endfunction

  function automatic script_row_t pinned_row(input logic [iis_pkg::PIX_W-1:0] p,
                                             input logic [iis_pkg::SUM_W-1:0] v,
                                             input logic re, input logic fe);
    script_row_t r;
    r = pixel_row(p);
    r.pinned = 1'b1;
    r.want.integral_value = v;
    r.want.row_end = re;
    r.want.frame_end = fe;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [iis_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [iis_pkg::CFG_W-1:0] val);
    script_row_t r;
    r = '0;
    r.kind = STEP_WRITE;
    r.index = idx;
    r.data = val;
    return r;
  endfunction

  task automatic drive_pixel(input logic [iis_pkg::PIX_W-1:0] p, input logic pinned,
                             input sat_result_t want);
    int gap;
    @(negedge clk);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      pix_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pin_now = pinned;
    pin_want = want;
    pix_bus.valid <= 1'b1;
    pix_bus.pixel <= p;
    do @(posedge clk); while (!pix_bus.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    pix_bus.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [iis_pkg::CFG_IDX_W-1:0] idx,
                           input logic [iis_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    int stall;
    stall = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && sink_stalls && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 14);
      if (stall != 0) begin
        stall--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sat_result_t want;
    sat_result_t calc;
    logic        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (res_bus.valid && res_bus.ready) begin
        moved = 1'b1;
        if (pending_sums.size() == 0) begin
          $error("integral_value: expected no transaction, got %0d", res_bus.integral_value);
          errors++;
        end else begin
          want = pending_sums.pop_front();
          if (res_bus.integral_value !== want.integral_value) begin
            $error("integral_value: expected %0d, got %0d",
                   want.integral_value, res_bus.integral_value);
            errors++;
          end
          if (res_bus.row_end !== want.row_end) begin
            $error("row_end: expected %0d, got %0d", want.row_end, res_bus.row_end);
            errors++;
          end
          if (res_bus.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, res_bus.frame_end);
            errors++;
          end
        end
      end
      if (pix_bus.valid && pix_bus.ready) begin
        moved = 1'b1;
        calc = next_integral(pix_bus.pixel);
        pending_sums.push_back(pin_now ? pin_want : calc);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        moved = 1'b1;
        case (cfg_bus.index)
          iis_pkg::REG_IMAGE_WIDTH:  width_reg = cfg_bus.data;
          iis_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_bus.data;
          default: ;
        endcase
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("integral_image_stream test failed");
    $finish;
  end

  initial begin
    int                        sent;
    int                        burst;
    int                        style;
    int                        plan;
    logic [iis_pkg::CFG_W-1:0] new_w;
    logic [iis_pkg::CFG_W-1:0] new_h;
    logic [iis_pkg::PIX_W-1:0] p;
    sat_result_t               no_pin;
    no_pin = '0;
    pix_bus.valid = 1'b0;
    pix_bus.pixel = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;

    script.push_back(pinned_row(8'd0, 32'd0, 1'b0, 1'b0));
    script.push_back(pinned_row(8'd255, 32'd255, 1'b0, 1'b0));
    script.push_back(reg_row(iis_pkg::REG_IMAGE_WIDTH, '0));
    script.push_back(pinned_row(8'd255, 32'd510, 1'b1, 1'b0));
    script.push_back(reg_row(iis_pkg::REG_IMAGE_HEIGHT, '0));
    script.push_back(pixel_row(8'd7));
    script.push_back(pinned_row(8'd255, 32'd255, 1'b1, 1'b1));
    script.push_back(reg_row(iis_pkg::REG_IMAGE_WIDTH, SIZE_CFG_MAX));
    script.push_back(reg_row(iis_pkg::REG_IMAGE_HEIGHT, SIZE_CFG_MAX));
    script.push_back(pixel_row(8'd255));
    script.push_back(pixel_row(8'd0));
    script.push_back(reg_row(iis_pkg::REG_IMAGE_WIDTH, iis_pkg::CFG_W'(1)));
    script.push_back(pixel_row(8'd255));
    script.push_back(reg_row(iis_pkg::REG_IMAGE_WIDTH, iis_pkg::CFG_W'(3)));
    script.push_back(reg_row(iis_pkg::REG_IMAGE_HEIGHT, iis_pkg::CFG_W'(2)));
    script.push_back(pixel_row(8'd255));
    script.push_back(pixel_row(8'd255));
    script.push_back(pixel_row(8'd255));
    script.push_back(reg_row(iis_pkg::REG_IMAGE_WIDTH, iis_pkg::CFG_W'(MAX_W)));
    script.push_back(reg_row(iis_pkg::REG_IMAGE_HEIGHT,
                             iis_pkg::CFG_W'(iis_pkg::HEIGHT_LIMIT)));
    script.push_back(reg_row(REG_SPARE_2, SIZE_CFG_MAX));
    script.push_back(reg_row(REG_SPARE_3, '0));
    script.push_back(pixel_row(8'd128));
    script.push_back(pixel_row(8'd1));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    foreach (script[i]) begin
      if (script[i].kind == STEP_WRITE) begin
        drain();
        write_reg(script[i].index, script[i].data);
      end else begin
        drive_pixel(script[i].pixel, script[i].pinned, script[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      src_gaps = (RANDOM_ITEMS - sent > CALM_TAIL) && $urandom_range(0, 3) != 0;
      sink_stalls = (RANDOM_ITEMS - sent > CALM_TAIL) && $urandom_range(0, 3) != 0;
      plan = $urandom_range(0, 3);
      if (plan != 3) begin
        case ($urandom_range(0, 15))
          0:       new_w = '0;
          1:       new_w = iis_pkg::CFG_W'(1);
          2:       new_w = iis_pkg::CFG_W'(MAX_W);
          3:       new_w = iis_pkg::CFG_W'($urandom_range(MAX_W + 1, 8191));
          4, 5:    new_w = iis_pkg::CFG_W'($urandom_range(17, 80));
          default: new_w = iis_pkg::CFG_W'($urandom_range(2, 16));
        endcase
        // hold later rows inside the columns already held in the line store
        if (row_pos != '0 && span_of(new_w, MAX_W) > store_span)
          new_w = iis_pkg::CFG_W'(store_span);
        write_reg(iis_pkg::REG_IMAGE_WIDTH, new_w);
      end
      if (plan != 2) begin
        case ($urandom_range(0, 15))
          0:       new_h = '0;
          1:       new_h = iis_pkg::CFG_W'(1);
          2:       new_h = iis_pkg::CFG_W'(iis_pkg::HEIGHT_LIMIT);
          3:       new_h = iis_pkg::CFG_W'($urandom_range(iis_pkg::HEIGHT_LIMIT + 1, 8191));
          default: new_h = iis_pkg::CFG_W'($urandom_range(2, 8));
        endcase
        write_reg(iis_pkg::REG_IMAGE_HEIGHT, new_h);
      end
      burst = $urandom_range(1, 160);
      style = $urandom_range(0, 3);
      repeat (burst) begin
        case (style)
          0:       p = '1;
          1:       p = '0;
          2:       p = ($urandom_range(0, 1) != 0) ? '1 : iis_pkg::PIX_W'($urandom);
          default: p = iis_pkg::PIX_W'($urandom);
        endcase
        drive_pixel(p, 1'b0, no_pin);
      end
      sent += burst;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("integral_image_stream test passed");
    end else begin
      $display("integral_image_stream test failed");
    end
    $finish;
  end

endmodule
